[src/mbeq_pkg.sv]
// ----------------------------------------------------------------------------
// mbeq_pkg
// types and constants shared by the band-pass equalizer block
// ----------------------------------------------------------------------------
package mbeq_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STATE_W  = 32;
    localparam int COEF_W   = 16;
    localparam int NUM_REGS = 8;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_sample_ch1;
        logic signed [SAMPLE_W-1:0] in_sample_ch0;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample_ch1;
        logic signed [SAMPLE_W-1:0] out_sample_ch0;
    } out_item_t;

endpackage

[src/multiband_bandpass_equalizer.sv]
// ----------------------------------------------------------------------------
// multiband_bandpass_equalizer
// two-channel graphic equaliser over a bank of band-pass biquad sections
// per band: a load step, three 16-bit serial products through one shared mac,
// a band step, a fourth product and a gain step; per channel a channel step
// a sample is taken only once the last one is processed; the next sample is
// taken while one result waits in the output register
// synchronous active-low reset clears coefficients and all filter history
// ----------------------------------------------------------------------------
module multiband_bandpass_equalizer #(
    parameter int BANDS    = 8,
    parameter int CHANNELS = 2
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  mbeq_pkg::in_item_t        s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output mbeq_pkg::out_item_t       m_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [5:0]                paddr,
    input  logic [63:0]               pwdata,
    output logic [63:0]               prdata,
    output logic                      pready
);

    localparam int BW  = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NS  = CHANNELS * BANDS;
    localparam int SW  = (NS > 1) ? $clog2(NS) : 1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_WAIT  = 7'b0001000,
        ST_BAND  = 7'b0010000,
        ST_GAIN  = 7'b0100000,
        ST_CHAN  = 7'b1000000
    } state_t;

    logic [63:0] coef_reg [mbeq_pkg::NUM_REGS];
    logic [31:0] y1_mem [NS];
    logic [31:0] y2_mem [NS];
    logic signed [15:0] xp_reg [CHANNELS];
    logic signed [15:0] xpp_reg [CHANNELS];

    state_t               st_reg, st_next;
    logic [CHW-1:0]       ch_reg;
    logic [BW-1:0]        bd_reg;
    logic [1:0]           ph_reg;
    logic signed [31:0]   y1_rd, y2_rd, y_reg;
    logic signed [63:0]   bacc_reg;
    mbeq_pkg::in_item_t   in_reg;
    mbeq_pkg::out_item_t  res_reg;
    mbeq_pkg::out_item_t  out_reg;
    logic                 out_full_reg;
    logic                 pend_reg;

    logic                 wr_en;
    logic [2:0]           widx;
    logic [SW-1:0]        sidx;
    logic [63:0]          cw;
    logic signed [15:0]   xin;
    logic signed [16:0]   diff;

    logic                 mac_start, mac_clr, mac_neg, mac_busy;
    logic signed [33:0]   mac_a;
    logic signed [15:0]   mac_b;
    logic signed [63:0]   mac_acc;

    logic signed [63:0]   rnd;
    logic signed [49:0]   fl;
    logic signed [31:0]   ysat;
    logic signed [63:0]   tq;
    logic signed [45:0]   rq;
    logic signed [15:0]   osat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = paddr[5:3];

    always_comb begin
        prdata = coef_reg[paddr[5:3]];
    end

    assign sidx = SW'(ch_reg) * SW'(BANDS) + SW'(bd_reg);
    assign cw   = coef_reg[bd_reg];
    assign xin  = (ch_reg == CHW'(0)) ? in_reg.in_sample_ch0 : in_reg.in_sample_ch1;
    assign diff = 17'(xin) - 17'(xpp_reg[ch_reg]);

    always_comb begin
        mac_a   = '0;
        mac_b   = '0;
        mac_neg = 1'b0;
        case (ph_reg)
            2'd0: begin
                mac_a = 34'(diff) <<< 8;
                mac_b = cw[15:0];
            end
            2'd1: begin
                mac_a = 34'(y1_rd);
                mac_b = cw[31:16];
            end
            2'd2: begin
                mac_a   = 34'(y2_rd);
                mac_b   = cw[47:32];
                mac_neg = 1'b1;
            end
            default: begin
                mac_a = 34'(y_reg);
                mac_b = cw[63:48];
            end
        endcase
    end

    mbeq_serial_mac #(.AW(34), .BW(16), .PW(64)) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .clr_acc (mac_clr),
        .neg     (mac_neg),
        .mcand   (mac_a),
        .mplier  (mac_b),
        .busy    (mac_busy),
        .acc     (mac_acc)
    );

    assign mac_start = (st_reg == ST_MUL);
    assign mac_clr   = (ph_reg == 2'd0) || (ph_reg == 2'd3);

    // band output: round half up to 8 fraction bits, saturate to 32 bits
    assign rnd  = mac_acc + 64'sd8192;
    assign fl   = 50'(rnd >>> 14);
    assign ysat = (fl > 50'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                  (fl < -50'sh80000000) ? 32'sh80000000 : fl[31:0];

    // output: truncate toward zero, saturate to 16 bits
    assign tq   = bacc_reg[63] ? -bacc_reg : bacc_reg;
    assign rq   = bacc_reg[63] ? -46'(tq >>> 18) : 46'(tq >>> 18);
    assign osat = (rq > 46'sd32767) ? 16'sh7FFF :
                  (rq < -46'sd32768) ? 16'sh8000 : rq[15:0];

    assign s_ready = (st_reg == ST_IDLE) && (!pend_reg || !out_full_reg);
    assign m_valid = out_full_reg;
    assign m_data  = out_reg;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (s_valid && s_ready) st_next = ST_LOAD;
            ST_LOAD: st_next = ST_MUL;
            ST_MUL:  st_next = ST_WAIT;
            ST_WAIT: begin
                if (!mac_busy) begin
                    if (ph_reg == 2'd2) st_next = ST_BAND;
                    else if (ph_reg == 2'd3) st_next = ST_GAIN;
                    else st_next = ST_MUL;
                end
            end
            ST_BAND: st_next = ST_MUL;
            ST_GAIN: begin
                if (bd_reg == BW'(BANDS - 1)) st_next = ST_CHAN;
                else st_next = ST_LOAD;
            end
            ST_CHAN: begin
                if (ch_reg == CHW'(CHANNELS - 1)) st_next = ST_IDLE;
                else st_next = ST_LOAD;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            out_full_reg <= 1'b0;
            pend_reg     <= 1'b0;
            ch_reg       <= '0;
            bd_reg       <= '0;
            ph_reg       <= '0;
            for (int i = 0; i < mbeq_pkg::NUM_REGS; i++) coef_reg[i] <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                xp_reg[i]  <= '0;
                xpp_reg[i] <= '0;
            end
            for (int i = 0; i < NS; i++) begin
                y1_mem[i] <= '0;
                y2_mem[i] <= '0;
            end
            res_reg <= '0;
            out_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (wr_en) coef_reg[widx] <= pwdata;
            if (pend_reg && (!out_full_reg || m_ready)) begin
                out_reg      <= res_reg;
                out_full_reg <= 1'b1;
                pend_reg     <= 1'b0;
            end else if (m_valid && m_ready) begin
                out_full_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        in_reg  <= s_data;
                        ch_reg  <= '0;
                        bd_reg  <= '0;
                        ph_reg  <= '0;
                        res_reg <= '0;
                    end
                end
                ST_LOAD: begin
                    y1_rd  <= y1_mem[sidx];
                    y2_rd  <= y2_mem[sidx];
                    ph_reg <= '0;
                end
                ST_WAIT: begin
                    if (!mac_busy && ph_reg != 2'd2 && ph_reg != 2'd3) ph_reg <= ph_reg + 2'd1;
                end
                ST_BAND: begin
                    y_reg        <= ysat;
                    y2_mem[sidx] <= y1_rd;
                    y1_mem[sidx] <= ysat;
                    ph_reg       <= 2'd3;
                end
                ST_GAIN: begin
                    bacc_reg <= (bd_reg == '0) ? mac_acc : bacc_reg + mac_acc;
                    if (bd_reg != BW'(BANDS - 1)) bd_reg <= bd_reg + BW'(1);
                end
                ST_CHAN: begin
                    xpp_reg[ch_reg] <= xp_reg[ch_reg];
                    xp_reg[ch_reg]  <= xin;
                    bd_reg          <= '0;
                    if (ch_reg == CHW'(0)) res_reg.out_sample_ch0 <= osat;
                    else res_reg.out_sample_ch1 <= osat;
                    if (ch_reg == CHW'(CHANNELS - 1)) pend_reg <= 1'b1;
                    else ch_reg <= ch_reg + CHW'(1);
                end
                default: ;
            endcase
        end
    end

endmodule

[src/mbeq_serial_mac.sv]
// ----------------------------------------------------------------------------
// mbeq_serial_mac
// bit-serial signed multiply-accumulate: one multiplier bit per cycle
// ----------------------------------------------------------------------------
module mbeq_serial_mac #(
    parameter int AW = 34,
    parameter int BW = 16,
    parameter int PW = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic                 clr_acc,
    input  logic                 neg,
    input  logic signed [AW-1:0] mcand,
    input  logic signed [BW-1:0] mplier,
    output logic                 busy,
    output logic signed [PW-1:0] acc
);

    localparam int CW = $clog2(BW + 1);

    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] mc_reg, mc_next;
    logic [BW-1:0]        mp_reg, mp_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic signed [PW-1:0] term;

    always_comb begin
        acc_next = acc_reg;
        mc_next  = mc_reg;
        mp_next  = mp_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        term     = '0;
        if (start) begin
            if (clr_acc) begin
                acc_next = '0;
            end
            mc_next  = PW'(mcand);
            mp_next  = mplier;
            neg_next = neg;
            cnt_next = CW'(BW);
        end else if (cnt_reg != '0) begin
            // top bit of a two's complement multiplier has negative weight
            if (mp_reg[0]) begin
                term = (cnt_reg == CW'(1)) ? -mc_reg : mc_reg;
            end
            acc_next = neg_reg ? acc_reg - term : acc_reg + term;
            mc_next  = mc_reg <<< 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            acc_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            acc_reg <= acc_next;
        end
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        neg_reg <= neg_next;
    end

    assign busy = (cnt_reg != '0) || start;
    assign acc  = acc_reg;

endmodule

[src/mbeq_checker.sv]
// ----------------------------------------------------------------------------
// mbeq_checker
// port-level checks on the equaliser handshakes
// ----------------------------------------------------------------------------
module mbeq_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic pready
);

    // result held until transfer
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("m_valid dropped");

    // offered sample held until transfer
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid) else $error("s_valid dropped");

    // the next sample waits until the last one is processed, so no second transfer right after one
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("s_ready right after transfer");

    a_pready: assert property (@(posedge aclk) pready) else $error("pready low");

endmodule

bind multiband_bandpass_equalizer mbeq_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .pready(pready)
);
